### design/dwo_pkg.sv
// Shared types, constants and lookup functions for the dead-wheel odometry core.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package dwo_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int POSITION_BITS = 48;
  localparam int CORDIC_STEPS  = 16;

  localparam int FRAC_BITS = POSITION_BITS - 32;
  localparam int CORDIC_N  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int STEP_W    = $clog2(CORDIC_N + 1);
  localparam int ZW        = ANGLE_BITS + 2;

  localparam logic signed [31:0] CORDIC_K_Q30 = 32'sd652032874;
  localparam logic signed [31:0] TWO_PI_Q21   = 32'sd13176795;

  typedef enum logic [2:0] {
    REG_NOISE_THRESHOLD = 3'd0,
    REG_SCALE_P         = 3'd1,
    REG_SCALE_Q         = 3'd2,
    REG_CROSS_P_FROM_Q  = 3'd3,
    REG_CROSS_Q_FROM_P  = 3'd4,
    REG_ROTATION_GAIN   = 3'd5,
    REG_MOUNT_ANGLE     = 3'd6
  } reg_index_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_P,
    MUL_Q,
    MUL_XPQ,
    MUL_XQP,
    MUL_GD,
    MUL_KH,
    MUL_KL,
    MUL_PC,
    MUL_QS,
    MUL_PS,
    MUL_QC
  } mul_op_t;

  typedef struct packed {
    logic    load;
    mul_op_t op;
    logic    limit;
    logic    pos;
    logic    publish;
  } dwo_cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MP,
    ST_MQ,
    ST_MGD,
    ST_MXPQ,
    ST_MXQP,
    ST_MKH,
    ST_MKL,
    ST_CORR,
    ST_LIM,
    ST_WAIT,
    ST_MPC,
    ST_MQS,
    ST_MPS,
    ST_MQC,
    ST_ACC,
    ST_POS,
    ST_PUB
  } state_t;

  // Arctangent of 2^-i as a fraction of a turn, scaled to ANGLE_BITS.
  function automatic logic [ANGLE_BITS-1:0] atan_angle(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0:  t = 32'd536870912;
      5'd1:  t = 32'd316933406;
      5'd2:  t = 32'd167458907;
      5'd3:  t = 32'd85004756;
      5'd4:  t = 32'd42667331;
      5'd5:  t = 32'd21354465;
      5'd6:  t = 32'd10679838;
      5'd7:  t = 32'd5340245;
      5'd8:  t = 32'd2670163;
      5'd9:  t = 32'd1335087;
      5'd10: t = 32'd667544;
      5'd11: t = 32'd333772;
      5'd12: t = 32'd166886;
      5'd13: t = 32'd83443;
      5'd14: t = 32'd41722;
      5'd15: t = 32'd20861;
      5'd16: t = 32'd10430;
      5'd17: t = 32'd5215;
      5'd18: t = 32'd2608;
      5'd19: t = 32'd1304;
      5'd20: t = 32'd652;
      5'd21: t = 32'd326;
      5'd22: t = 32'd163;
      5'd23: t = 32'd81;
      default: t = 32'd0;
    endcase
    return ANGLE_BITS'(t >> (32 - ANGLE_BITS));
  endfunction

endpackage

### design/dead_wheel_odometry_core.sv
// Dead-wheel odometry core: two encoder deltas and a heading in, X/Y position out.
// One item at a time: the next item is accepted in the cycle after publish, and a clear
// item goes straight to publish. An item runs the shared multiplier passes and waits on
// the 16-step iterative CORDIC before the rotation products; publish waits on the output.
// Reset (rst, synchronous, active high) restores register defaults, zeroes position
// and heading history, and empties the output register.
`timescale 1ns / 1ps

module dead_wheel_odometry_core import dwo_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // Configuration write port
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [23:0]  cfg_wdata,
  // Input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // delta_p_count[15:0], delta_q_count[31:16], heading[47:32]
  input  logic         s_tuser,   // clear_origin
  // Output stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata    // pos_x[31:0], pos_y[63:32], dist_p[87:64], dist_q[111:88]
);

  dwo_cmd_t           cmd;
  logic               cordic_done;
  logic [15:0]        angle_sum;
  logic signed [31:0] cos_q30;
  logic signed [31:0] sin_q30;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [23:0] dist_p;
  logic signed [23:0] dist_q;

  // Sequence the item; hold the result in the output register until taken.
  dwo_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_clear     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .cordic_done (cordic_done),
    .cmd         (cmd)
  );

  // Start the rotation on accept so it runs alongside the distance arithmetic.
  dwo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.load),
    .angle   (angle_sum),
    .done    (cordic_done),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  dwo_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_cp     (s_tdata[15:0]),
    .in_cq     (s_tdata[31:16]),
    .in_head   (s_tdata[47:32]),
    .in_clear  (s_tuser),
    .cmd       (cmd),
    .cos_q30   (cos_q30),
    .sin_q30   (sin_q30),
    .angle_sum (angle_sum),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .dist_p    (dist_p),
    .dist_q    (dist_q)
  );

  assign m_tdata = {dist_q, dist_p, pos_y, pos_x};

  // One item at a time: after an accept, input stays closed the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in flight");

  // Never overwrite a result that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> (!m_tvalid || m_tready))
    else $error("publish over a pending result");

  // Rotation products use finished sine and cosine.
  a_cordic_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == MUL_PC || cmd.op == MUL_QS || cmd.op == MUL_PS || cmd.op == MUL_QC)
      |-> cordic_done)
    else $error("rotation multiply before CORDIC finished");

endmodule

### design/dwo_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, cos and sin in Q30.
// Depends on dwo_pkg.
`timescale 1ns / 1ps

module dwo_cordic import dwo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [15:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);

  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (ANGLE_BITS - 2);
  localparam logic signed [ZW-1:0] HALF    = ZW'(1) <<< (ANGLE_BITS - 1);

  logic signed [33:0]     x;
  logic signed [33:0]     y;
  logic signed [ZW-1:0]   z;
  logic                   neg;
  logic                   busy;
  logic [STEP_W-1:0]      cnt;

  logic [ANGLE_BITS+15:0] wide;
  logic [ANGLE_BITS-1:0]  phase;
  logic signed [ZW-1:0]   z0;
  logic signed [ZW-1:0]   zf;
  logic                   nf;
  logic signed [ZW-1:0]   a;

  always_comb begin
    wide  = {angle, ANGLE_BITS'(0)};
    phase = ANGLE_BITS'(wide >> 16);
    z0    = ZW'(signed'(phase));
    zf    = z0;
    nf    = 1'b0;
    if (z0 > QUARTER) begin
      zf = z0 - HALF;
      nf = 1'b1;
    end else if (z0 < -QUARTER) begin
      zf = z0 + HALF;
      nf = 1'b1;
    end
    a = ZW'(atan_angle(5'(cnt)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + STEP_W'(1);
      if (cnt == STEP_W'(CORDIC_N - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x   <= 34'(CORDIC_K_Q30);
      y   <= '0;
      z   <= zf;
      neg <= nf;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - (y >>> cnt);
        y <= y + (x >>> cnt);
        z <= z - a;
      end else begin
        x <= x + (y >>> cnt);
        y <= y - (x >>> cnt);
        z <= z + a;
      end
    end
  end

  assign cos_q30 = neg ? 32'(-x) : 32'(x);
  assign sin_q30 = neg ? 32'(-y) : 32'(y);

endmodule

### design/dwo_datapath.sv
// Datapath: configuration registers, shared multiplier, distance and position arithmetic.
// Depends on dwo_pkg; steered by dwo_cmd_t from the controller.
`timescale 1ns / 1ps

module dwo_datapath import dwo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [23:0]        cfg_wdata,
  input  logic signed [15:0] in_cp,
  input  logic signed [15:0] in_cq,
  input  logic [15:0]        in_head,
  input  logic               in_clear,
  input  dwo_cmd_t           cmd,
  input  logic signed [31:0] cos_q30,
  input  logic signed [31:0] sin_q30,
  output logic [15:0]        angle_sum,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [23:0] dist_p,
  output logic signed [23:0] dist_q
);

  localparam int RSH = (FRAC_BITS <= 30) ? (30 - FRAC_BITS) : 0;
  localparam int LSH = (FRAC_BITS > 30) ? (FRAC_BITS - 30) : 0;
  localparam logic signed [63:0] RBIAS = (64'sd1 <<< RSH) >>> 1;

  logic [15:0]        noise_threshold;
  logic signed [23:0] scale_p;
  logic signed [23:0] scale_q;
  logic signed [15:0] cross_p_from_q;
  logic signed [15:0] cross_q_from_p;
  logic signed [23:0] rotation_gain;
  logic [15:0]        mount_angle;

  logic [POSITION_BITS-1:0] position_x;
  logic [POSITION_BITS-1:0] position_y;
  logic [15:0]              last_heading;
  logic                     last_heading_valid;

  logic signed [15:0] cp;
  logic signed [15:0] cq;
  logic               p_live;
  logic               q_live;
  logic signed [16:0] dyaw;
  logic signed [27:0] raw_p;
  logic signed [27:0] raw_q;
  logic signed [29:0] base_p;
  logic signed [29:0] base_q;
  logic signed [40:0] pgd;
  logic signed [65:0] kacc;
  logic signed [24:0] corr;
  logic signed [23:0] lp;
  logic signed [23:0] lq;
  logic signed [63:0] macc;
  logic signed [63:0] sx;
  logic signed [63:0] sy;

  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] prod;
  mul_op_t            prod_op;

  logic signed [16:0] cp17;
  logic signed [16:0] cq17;
  logic signed [16:0] abs_p;
  logic signed [16:0] abs_q;
  logic [15:0]        dh;
  logic signed [16:0] dyaw_new;
  logic signed [63:0] r12p;
  logic signed [63:0] r12q;
  logic signed [63:0] r15;
  logic signed [27:0] rp_cut;
  logic signed [27:0] rq_cut;
  logic signed [28:0] x15;
  logic signed [45:0] kh;
  logic signed [65:0] kfull;
  logic signed [65:0] kround;
  logic signed [31:0] dpl;
  logic signed [31:0] dql;
  logic signed [63:0] dx;
  logic signed [63:0] dy;

  assign angle_sum = in_head + mount_angle;

  // Configuration writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      noise_threshold <= 16'd0;
      scale_p         <= 24'sd65536;
      scale_q         <= 24'sd65536;
      cross_p_from_q  <= '0;
      cross_q_from_p  <= '0;
      rotation_gain   <= '0;
      mount_angle     <= '0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_addr))
        REG_NOISE_THRESHOLD: noise_threshold <= cfg_wdata[15:0];
        REG_SCALE_P:         scale_p         <= cfg_wdata;
        REG_SCALE_Q:         scale_q         <= cfg_wdata;
        REG_CROSS_P_FROM_Q:  cross_p_from_q  <= cfg_wdata[15:0];
        REG_CROSS_Q_FROM_P:  cross_q_from_p  <= cfg_wdata[15:0];
        REG_ROTATION_GAIN:   rotation_gain   <= cfg_wdata;
        REG_MOUNT_ANGLE:     mount_angle     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cp17     = 17'(in_cp);
    cq17     = 17'(in_cq);
    abs_p    = (cp17 < 0) ? -cp17 : cp17;
    abs_q    = (cq17 < 0) ? -cq17 : cq17;
    dh       = in_head - last_heading;
    if (!last_heading_valid) begin
      dyaw_new = '0;
    end else if (dh == 16'h8000) begin
      dyaw_new = 17'sd32768;
    end else begin
      dyaw_new = 17'(signed'(dh));
    end
  end

  // Shared multiplier operand select.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      MUL_P:   begin ma = 32'(cp);     mb = 32'(scale_p);        end
      MUL_Q:   begin ma = 32'(cq);     mb = 32'(scale_q);        end
      MUL_XPQ: begin ma = 32'(raw_q);  mb = 32'(cross_p_from_q); end
      MUL_XQP: begin ma = 32'(raw_p);  mb = 32'(cross_q_from_p); end
      MUL_GD:  begin ma = 32'(rotation_gain); mb = 32'(dyaw);    end
      MUL_KH:  begin ma = 32'(signed'(pgd[40:20])); mb = TWO_PI_Q21; end
      MUL_KL:  begin ma = 32'({1'b0, pgd[19:0]}); mb = TWO_PI_Q21; end
      MUL_PC:  begin ma = 32'(lp);     mb = cos_q30;             end
      MUL_QS:  begin ma = 32'(lq);     mb = sin_q30;             end
      MUL_PS:  begin ma = 32'(lp);     mb = sin_q30;             end
      MUL_QC:  begin ma = 32'(lq);     mb = cos_q30;             end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_op <= MUL_NONE;
    end else begin
      prod_op <= cmd.op;
    end
  end

  always_ff @(posedge clk) begin
    prod <= 64'(ma) * 64'(mb);
  end

  always_comb begin
    r12p   = (prod + 64'sd2048) >>> 12;
    r12q   = (-prod + 64'sd2048) >>> 12;
    r15    = (prod + 64'sd16384) >>> 15;
    rp_cut = r12p[27:0];
    rq_cut = r12q[27:0];
    x15    = r15[28:0];
    kh     = prod[45:0];
    kfull  = kacc + 66'(prod);
    kround = (kfull + (66'sd1 <<< 40)) >>> 41;
    dpl    = 32'(base_p) - 32'(corr);
    dql    = 32'(base_q) + 32'(corr);
    dx     = ((sx + RBIAS) >>> RSH) <<< LSH;
    dy     = ((sy + RBIAS) >>> RSH) <<< LSH;
  end

  // Heading and position state.
  always_ff @(posedge clk) begin
    if (rst) begin
      position_x         <= '0;
      position_y         <= '0;
      last_heading       <= '0;
      last_heading_valid <= 1'b0;
    end else if (cmd.load) begin
      if (in_clear) begin
        position_x         <= '0;
        position_y         <= '0;
        last_heading       <= '0;
        last_heading_valid <= 1'b0;
      end else begin
        last_heading       <= in_head;
        last_heading_valid <= 1'b1;
      end
    end else if (cmd.pos) begin
      position_x <= position_x + POSITION_BITS'(dx);
      position_y <= position_y + POSITION_BITS'(dy);
    end
  end

  // Item latch and product captures; each capture takes the registered product in the cycle after its multiply.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cp     <= in_cp;
      cq     <= in_cq;
      p_live <= abs_p > 17'(noise_threshold);
      q_live <= abs_q > 17'(noise_threshold);
      dyaw   <= dyaw_new;
      if (in_clear) begin
        lp <= '0;
        lq <= '0;
      end
    end
    if (cmd.limit) begin
      lp <= (dpl > 32'sd8388607) ? 24'sh7FFFFF :
            (dpl < -32'sd8388608) ? 24'sh800000 : 24'(dpl);
      lq <= (dql > 32'sd8388607) ? 24'sh7FFFFF :
            (dql < -32'sd8388608) ? 24'sh800000 : 24'(dql);
    end
    case (prod_op)
      MUL_P:   raw_p  <= p_live ? rp_cut : '0;
      MUL_Q:   raw_q  <= q_live ? rq_cut : '0;
      MUL_XPQ: base_p <= 30'(raw_p) + 30'(x15);
      MUL_XQP: base_q <= 30'(raw_q) + 30'(x15);
      MUL_GD:  pgd    <= prod[40:0];
      MUL_KH:  kacc   <= {kh, 20'd0};
      MUL_KL:  corr   <= kround[24:0];
      MUL_PC:  macc   <= prod;
      MUL_QS:  sx     <= macc - prod;
      MUL_PS:  macc   <= prod;
      MUL_QC:  sy     <= macc + prod;
      default: ;
    endcase
  end

  // Result register, separate from the working state.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      pos_x  <= position_x[FRAC_BITS +: 32];
      pos_y  <= position_y[FRAC_BITS +: 32];
      dist_p <= lp;
      dist_q <= lq;
    end
  end

endmodule

### design/dwo_ctrl.sv
// Controller: sequences the shared multiplier, waits on the CORDIC, owns the handshakes.
// Depends on dwo_pkg.
`timescale 1ns / 1ps

module dwo_ctrl import dwo_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic     s_clear,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  logic     cordic_done,
  output dwo_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.op      = MUL_NONE;
    s_tready    = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = s_clear ? ST_PUB : ST_MP;
        end
      end
      ST_MP:   begin cmd.op = MUL_P;   state_next = ST_MQ;   end
      ST_MQ:   begin cmd.op = MUL_Q;   state_next = ST_MGD;  end
      ST_MGD:  begin cmd.op = MUL_GD;  state_next = ST_MXPQ; end
      ST_MXPQ: begin cmd.op = MUL_XPQ; state_next = ST_MXQP; end
      ST_MXQP: begin cmd.op = MUL_XQP; state_next = ST_MKH;  end
      ST_MKH:  begin cmd.op = MUL_KH;  state_next = ST_MKL;  end
      ST_MKL:  begin cmd.op = MUL_KL;  state_next = ST_CORR; end
      ST_CORR: state_next = ST_LIM;
      ST_LIM:  begin cmd.limit = 1'b1; state_next = ST_WAIT; end
      ST_WAIT: begin
        if (cordic_done) begin
          state_next = ST_MPC;
        end
      end
      ST_MPC:  begin cmd.op = MUL_PC;  state_next = ST_MQS;  end
      ST_MQS:  begin cmd.op = MUL_QS;  state_next = ST_MPS;  end
      ST_MPS:  begin cmd.op = MUL_PS;  state_next = ST_MQC;  end
      ST_MQC:  begin cmd.op = MUL_QC;  state_next = ST_ACC;  end
      ST_ACC:  state_next = ST_POS;
      ST_POS:  begin cmd.pos = 1'b1;   state_next = ST_PUB;  end
      ST_PUB: begin
        if (!out_valid || m_tready) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### test/tb_dead_wheel_odometry_core.sv
// Self-checking bench for dead_wheel_odometry_core: drives encoder/heading items, predicts
// position and compensated distances in a behavioral model, compares every output item.
// Depends on dwo_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_dead_wheel_odometry_core import dwo_pkg::*;;

  typedef struct packed {
    logic        clr;
    logic [15:0] head;
    logic [15:0] dq;
    logic [15:0] dp;
  } odo_item_t;

  typedef struct packed {
    logic [23:0] dq;
    logic [23:0] dp;
    logic [31:0] py;
    logic [31:0] px;
  } odo_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [23:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;   // delta_p_count, delta_q_count, heading
  logic         s_tuser = 1'b0; // clear_origin
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;        // pos_x, pos_y, dist_p, dist_q

  dead_wheel_odometry_core DUT (.*);

  always #1 clk = ~clk;

  // Model state and register shadow
  logic [15:0] thr_r;
  logic signed [23:0] scale_p_r, scale_q_r, gain_r;
  logic signed [15:0] xpq_r, xqp_r, mount_r;
  logic [47:0] odo_x, odo_y;
  logic [15:0] prev_head;
  logic        prev_head_ok;

  odo_item_t   pending_items[$];
  odo_result_t expected_results[$];
  int          n_fail = 0;
  int          n_sent = 0;
  bit          quiet_in, quiet_out;

  localparam int NF = POSITION_BITS - 32;

  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic logic [31:0] atan_turn(int i);
    logic [31:0] t [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  // Sine/cosine of a binary angle in Q30 by rotation-mode CORDIC with quadrant fold.
  task automatic sin_cos(input logic [15:0] ang, output longint c, output longint s);
    longint z, x, y, a, xs, ys, quarter, half;
    logic [63:0] ph;
    bit flip;
    ph = ANGLE_BITS >= 16 ? (64'(ang) << (ANGLE_BITS - 16)) : (64'(ang) >> (16 - ANGLE_BITS));
    z = ph[ANGLE_BITS-1] ? longint'(ph[ANGLE_BITS-1:0]) - (64'sd1 <<< ANGLE_BITS)
                         : longint'(ph[ANGLE_BITS-1:0]);
    quarter = 64'sd1 <<< (ANGLE_BITS - 2);
    half = 64'sd1 <<< (ANGLE_BITS - 1);
    x = CORDIC_K_Q30;
    y = 0;
    flip = 0;
    if (z > quarter) begin z -= half; flip = 1; end
    else if (z < -quarter) begin z += half; flip = 1; end
    for (int i = 0; i < CORDIC_N; i++) begin
      a = longint'(atan_turn(i) >> (32 - ANGLE_BITS));
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin x -= ys; y += xs; z -= a; end
      else begin x += ys; y -= xs; z += a; end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint to_fraction(longint acc);
    if (NF <= 30) return round_shift(acc, 30 - NF);
    return acc * (64'sd1 <<< ((NF - 30) & 7));
  endfunction

  // Advance the odometry model by one item and return the expected output.
  task automatic odometry_update(input odo_item_t it, output odo_result_t r);
    longint cp, cq, rp, rq, bp, bq, dyaw, corr, lp, lq, c, s;
    logic [15:0] d16;
    r = '0;
    if (it.clr) begin
      odo_x = '0; odo_y = '0; prev_head = '0; prev_head_ok = 0;
      return;
    end
    cp = longint'($signed(it.dp));
    cq = longint'($signed(it.dq));
    rp = 0; rq = 0; dyaw = 0;
    if ((cp < 0 ? -cp : cp) > longint'(thr_r)) rp = round_shift(cp * scale_p_r, 12);
    if ((cq < 0 ? -cq : cq) > longint'(thr_r)) rq = round_shift(-(cq * scale_q_r), 12);
    bp = rp + round_shift(rq * xpq_r, 15);
    bq = rq + round_shift(rp * xqp_r, 15);
    if (prev_head_ok) begin
      d16 = it.head - prev_head;
      dyaw = longint'($signed(d16));
      if (dyaw == -32768) dyaw = 32768;  // half turn counts positive
    end
    prev_head_ok = 1;
    prev_head = it.head;
    corr = round_shift(longint'(gain_r) * dyaw * longint'(TWO_PI_Q21), 41);
    lp = clamp24(bp - corr);
    lq = clamp24(bq + corr);
    sin_cos(it.head + mount_r, c, s);
    odo_x = odo_x + 48'(to_fraction(lp * c - lq * s));
    odo_y = odo_y + 48'(to_fraction(lp * s + lq * c));
    r.px = odo_x[NF +: 32];
    r.py = odo_y[NF +: 32];
    r.dp = lp[23:0];
    r.dq = lq[23:0];
  endtask

  // Driver: present pending items, hold until accepted, idle at random.
  always @(posedge clk) begin
    odo_item_t it;
    odo_result_t r;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        it = {s_tuser, s_tdata};
        odometry_update(it, r);
        expected_results.push_back(r);
        n_sent <= n_sent + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && (quiet_in || $urandom_range(99) >= 25)) begin
          it = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= it[47:0];
          s_tuser <= it.clr;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare each accepted output item.
  always @(posedge clk) begin
    odo_result_t got, want;
    if (!rst) begin
      m_tready <= quiet_out || $urandom_range(99) >= 25;
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_results.size() == 0) begin
          $error("unexpected output item %h", m_tdata);
          n_fail++;
        end else begin
          want = expected_results.pop_front();
          if (got.px !== want.px) begin
            $error("pos_x expected %h got %h", want.px, got.px); n_fail++;
          end
          if (got.py !== want.py) begin
            $error("pos_y expected %h got %h", want.py, got.py); n_fail++;
          end
          if (got.dp !== want.dp) begin
            $error("dist_p expected %h got %h", want.dp, got.dp); n_fail++;
          end
          if (got.dq !== want.dq) begin
            $error("dist_q expected %h got %h", want.dq, got.dq); n_fail++;
          end
        end
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [23:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_NOISE_THRESHOLD: thr_r = v[15:0];
      REG_SCALE_P:         scale_p_r = v;
      REG_SCALE_Q:         scale_q_r = v;
      REG_CROSS_P_FROM_Q:  xpq_r = v[15:0];
      REG_CROSS_Q_FROM_P:  xqp_r = v[15:0];
      REG_ROTATION_GAIN:   gain_r = v;
      REG_MOUNT_ANGLE:     mount_r = v[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for all queued items to go in and all results to come out.
  task automatic drain;
    wait (pending_items.size() == 0 && !s_tvalid);
    wait (expected_results.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic odo_item_t motion(logic [15:0] p, logic [15:0] q, logic [15:0] h);
    return {1'b0, h, q, p};
  endfunction

  // Mostly small realistic deltas and slow heading drift, some full-range noise.
  task automatic queue_random(int n);
    logic [15:0] h;
    odo_item_t it;
    h = $urandom;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: it = {1'b0, 16'($urandom), 16'($urandom), 16'($urandom)};
        1: it = {($urandom_range(3) == 0), 16'($urandom), 16'($urandom), 16'($urandom)};
        default: begin
          h += 16'($signed($urandom_range(400)) - 200);
          it = motion(16'($signed($urandom_range(600)) - 300),
                      16'($signed($urandom_range(600)) - 300), h);
        end
      endcase
      pending_items.push_back(it);
    end
  endtask

  initial begin
    thr_r = 0; scale_p_r = 65536; scale_q_r = 65536; xpq_r = 0; xqp_r = 0;
    gain_r = 0; mount_r = 0;
    odo_x = '0; odo_y = '0; prev_head = '0; prev_head_ok = 0;
    quiet_in = 0; quiet_out = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, half-turn heading step, clear, threshold edge.
    write_reg(REG_NOISE_THRESHOLD, 24'd3);
    write_reg(REG_ROTATION_GAIN, 24'd5000);
    pending_items.push_back(motion(16'h7fff, 16'h8000, 16'h0000));
    pending_items.push_back(motion(16'h8000, 16'h7fff, 16'h8000));
    pending_items.push_back(motion(16'd3, 16'hfffd, 16'h0000));
    pending_items.push_back(motion(16'd4, 16'hfffc, 16'h4000));
    pending_items.push_back(motion(16'hffff, 16'h0001, 16'hc000));
    pending_items.push_back(motion(16'd100, 16'd0, 16'h2000));
    pending_items.push_back({1'b1, 16'hffff, 16'hffff, 16'hffff});
    pending_items.push_back(motion(16'd50, 16'd50, 16'h6000));
    pending_items.push_back(motion(16'd50, 16'd50, 16'he000));
    pending_items.push_back(motion(16'h0, 16'h0, 16'h7fff));
    pending_items.push_back(motion(16'h1234, 16'hedcb, 16'hffff));
    drain();

    // Extreme gains, first with every count under the noise threshold, then with the threshold at zero.
    write_reg(REG_SCALE_P, 24'h7fffff);
    write_reg(REG_SCALE_Q, 24'h800000);
    write_reg(REG_CROSS_P_FROM_Q, 24'h007fff);
    write_reg(REG_CROSS_Q_FROM_P, 24'h008000);
    write_reg(REG_ROTATION_GAIN, 24'h800000);
    write_reg(REG_MOUNT_ANGLE, 24'h008000);
    write_reg(REG_NOISE_THRESHOLD, 24'h00ffff);
    pending_items.push_back(motion(16'h8000, 16'h7fff, 16'h1000));
    pending_items.push_back(motion(16'h8000, 16'h7fff, 16'h9000));
    drain();
    write_reg(REG_NOISE_THRESHOLD, 24'd0);
    pending_items.push_back(motion(16'h8000, 16'h7fff, 16'h1000));
    pending_items.push_back(motion(16'h7fff, 16'h8000, 16'h9000));
    queue_random(50);
    drain();

    // Random phases under several settings; one phase with no idling.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_NOISE_THRESHOLD, 24'($urandom_range(ph == 5 ? 65535 : 8)));
      write_reg(REG_SCALE_P, 24'($urandom_range(200000) - 100000));
      write_reg(REG_SCALE_Q, 24'($urandom_range(200000) - 100000));
      write_reg(REG_CROSS_P_FROM_Q, 24'($urandom));
      write_reg(REG_CROSS_Q_FROM_P, 24'($urandom));
      write_reg(REG_ROTATION_GAIN, ph == 4 ? 24'h7fffff : 24'($urandom));
      write_reg(REG_MOUNT_ANGLE, 24'($urandom));
      quiet_in = (ph == 2);
      quiet_out = (ph == 2);
      queue_random(150);
      drain();
    end

    if (n_fail == 0) begin
      $display("dead_wheel_odometry_core verification clean");
    end else begin
      $display("dead_wheel_odometry_core verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("dead_wheel_odometry_core verification failed");
    $finish;
  end

endmodule
